/* sv/idafr_pkg.sv */
// Shared types and codes for the ID allocator with a free-range table.
// No dependencies; imported by every module of the block.
package idafr_pkg;

	localparam int ID_W = 16;

	typedef struct packed {
		logic [ID_W-1:0] lo;
		logic [ID_W-1:0] hi;
	} range_t;

	typedef enum logic [1:0] {
		MODE_RANDOM = 2'd0,
		MODE_ASC    = 2'd1,
		MODE_DESC   = 2'd2,
		MODE_UNDEF  = 2'd3
	} order_mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ID   = 2'd1,
		ST_IGNORED = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_ORDER_MODE  = 1'b0;
	localparam logic CFG_START_VALUE = 1'b1;

endpackage

/* sv/idafr_table.sv */
// Range table storage: one write port, one read port with registered data.
// Depends on idafr_pkg for the range entry type.
module idafr_table #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  idafr_pkg::range_t wdata,
	input  logic [AW-1:0]     raddr,
	output idafr_pkg::range_t rdata
);
	import idafr_pkg::*;

	range_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/id_allocator_free_ranges.sv */
// Allocate: the sequencer passes through ALLOC and strobes the result once back in idle;
// taking the last ID of the lowest range first moves the higher entries down one slot in
// SHDN to close the gap. Free: SCAN walks to the insertion point p; to open a slot, SHUP
// moves entries up and INS places a new range, or SHDN closes the gap after a double join
// (one table word per cycle through the write port). A new request is taken in the strobe
// cycle. Reset (async, active low) loads ascending mode, counter 0, empty table.
module id_allocator_free_ranges #(
	parameter int ID_LIMIT      = 65534,
	parameter int INVALID_VALUE = 65535,
	parameter int MAX_RANGES    = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request side
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [idafr_pkg::ID_W-1:0] id_in,
	// result side, one word per request, strobed by done
	output logic                       done,
	output logic [idafr_pkg::ID_W-1:0] id_out,
	output logic [1:0]                 status,
	output logic                       in_fallback,
	// configuration writes
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [idafr_pkg::ID_W-1:0] cfg_wdata
);
	import idafr_pkg::*;

	// IW indexes the table, CW counts ranges up to MAX_RANGES itself
	localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [ID_W-1:0] LIMIT   = ID_W'(ID_LIMIT);
	localparam logic [ID_W-1:0] INVALID = ID_W'(INVALID_VALUE);
	localparam logic [CW-1:0]   CNT_MAX = CW'(MAX_RANGES);
	localparam logic [CW-1:0]   CNT_ONE = CW'(1);

	// Sequencer states. SCAN walks the sorted table one entry per cycle; SHDN
	// and SHUP move entries down or up by one slot; INS places a new range.
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ALLOC = 6'b000010,
		S_SCAN  = 6'b000100,
		S_SHDN  = 6'b001000,
		S_SHUP  = 6'b010000,
		S_INS   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [1:0]      mode_q;
	logic [ID_W-1:0] start_q;

	// allocator state
	logic [ID_W-1:0] ctr_q, ctr_d;
	logic            fb_q, fb_d;
	logic [CW-1:0]   cnt_q, cnt_d;

	// per-request working registers
	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] res_id_q, res_id_d;
	logic [CW-1:0]   p_q, p_d;       // scan position: index of the entry now on rdata
	logic [IW-1:0]   j_q, j_d;       // shift position: index of the entry now on rdata
	range_t          prev_q, prev_d; // entry just below the scan position

	// result registers
	logic            done_q;
	logic [ID_W-1:0] id_out_q;
	logic [1:0]      status_q;

	// table port
	logic          tbl_we;
	logic [IW-1:0] tbl_waddr;
	range_t        tbl_wdata;
	logic [IW-1:0] tbl_raddr;
	range_t        tbl_rdata;

	// finish of the current request
	logic            fin;
	logic [ID_W-1:0] fin_id;
	status_t         fin_st;

	// free-path compares: the ID against its limits, the entry on rdata and the saved neighbor, plus position checks
	logic            id_bad, scan_more, has_prev, cur_ok, dup, left, right;
	logic [ID_W:0]   prev_hi_p1, id_p1;
	logic [CW-1:0]   p_m1, p_p1, cnt_m1, j_p1;

	idafr_table #(
		.DEPTH(MAX_RANGES),
		.AW   (IW)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	assign id_bad     = (id_q == INVALID) || (id_q > LIMIT);
	assign has_prev   = (p_q != '0);
	assign cur_ok     = (p_q < cnt_q);
	assign scan_more  = cur_ok && (tbl_rdata.lo <= id_q);
	assign dup        = has_prev && (id_q <= prev_q.hi);
	assign prev_hi_p1 = {1'b0, prev_q.hi} + {{ID_W{1'b0}}, 1'b1};
	assign id_p1      = {1'b0, id_q} + {{ID_W{1'b0}}, 1'b1};
	assign left       = has_prev && (prev_hi_p1 == {1'b0, id_q});
	assign right      = cur_ok && ({1'b0, tbl_rdata.lo} == id_p1);
	assign p_m1       = p_q - CNT_ONE;
	assign p_p1       = p_q + CNT_ONE;
	assign cnt_m1     = cnt_q - CNT_ONE;
	assign j_p1       = CW'(j_q) + CNT_ONE;

	always_comb begin
		state_d   = state_q;
		ctr_d     = ctr_q;
		fb_d      = fb_q;
		cnt_d     = cnt_q;
		res_id_d  = res_id_q;
		p_d       = p_q;
		j_d       = j_q;
		prev_d    = prev_q;
		tbl_we    = 1'b0;
		tbl_waddr = '0;
		tbl_wdata = tbl_rdata;
		tbl_raddr = '0;
		fin       = 1'b0;
		fin_id    = res_id_q;
		fin_st    = ST_OK;

		case (state_q)
			S_IDLE: begin
				// entry 0 is fetched here so that it sits on rdata next cycle
				if (start) begin
					res_id_d = id_in;
					p_d      = '0;
					state_d  = (op == OP_FREE) ? S_SCAN : S_ALLOC;
				end
			end

			S_ALLOC: begin : alloc_blk
				logic use_ctr;
				logic use_pool;
				logic [ID_W-1:0] ctr_nx;
				use_ctr  = 1'b0;
				use_pool = 1'b0;
				ctr_nx   = ctr_q;
				case (mode_q)
					MODE_RANDOM: begin
						if (cnt_q != '0) begin
							use_pool = 1'b1;
						end else if (ctr_q < LIMIT) begin
							use_ctr = 1'b1;
							ctr_nx  = ctr_q + 1'b1;
						end
					end
					MODE_ASC: begin
						if (!fb_q && (ctr_q < LIMIT)) begin
							use_ctr = 1'b1;
							ctr_nx  = ctr_q + 1'b1;
						end else begin
							fb_d     = 1'b1;
							use_pool = 1'b1;
						end
					end
					MODE_DESC: begin
						if (!fb_q && (ctr_q != '0) && (ctr_q <= LIMIT)) begin
							use_ctr = 1'b1;
							ctr_nx  = ctr_q - 1'b1;
						end else begin
							fb_d     = 1'b1;
							use_pool = 1'b1;
						end
					end
					default: begin
					end
				endcase

				if (use_ctr) begin
					ctr_d   = ctr_nx;
					fin     = 1'b1;
					fin_id  = ctr_q;
					state_d = S_IDLE;
				end else if (use_pool && (cnt_q != '0)) begin
					// take the low end of the lowest range
					res_id_d = tbl_rdata.lo;
					if (tbl_rdata.lo == tbl_rdata.hi) begin
						if (cnt_q > CNT_ONE) begin
							// close the gap: pull entries 1.. down one slot
							tbl_raddr = IW'(1);
							j_d       = IW'(1);
							state_d   = S_SHDN;
						end else begin
							cnt_d   = cnt_m1;
							fin     = 1'b1;
							fin_id  = tbl_rdata.lo;
							state_d = S_IDLE;
						end
					end else begin
						tbl_we       = 1'b1;
						tbl_waddr    = '0;
						tbl_wdata.lo = tbl_rdata.lo + 1'b1;
						tbl_wdata.hi = tbl_rdata.hi;
						fin          = 1'b1;
						fin_id       = tbl_rdata.lo;
						state_d      = S_IDLE;
					end
				end else begin
					fin     = 1'b1;
					fin_id  = INVALID;
					fin_st  = ST_NO_ID;
					state_d = S_IDLE;
				end
			end

			S_SCAN: begin
				if (id_bad) begin
					fin     = 1'b1;
					fin_st  = ST_IGNORED;
					state_d = S_IDLE;
				end else if (scan_more) begin
					// advance: keep this entry as the left neighbor, fetch the next
					prev_d    = tbl_rdata;
					p_d       = p_p1;
					tbl_raddr = p_p1[IW-1:0];
				end else if (dup) begin
					fin     = 1'b1;
					fin_st  = ST_IGNORED;
					state_d = S_IDLE;
				end else if (left && right) begin
					// join both neighbors into the left one, then drop the right one
					tbl_we       = 1'b1;
					tbl_waddr    = p_m1[IW-1:0];
					tbl_wdata.lo = prev_q.lo;
					tbl_wdata.hi = tbl_rdata.hi;
					if (p_p1 < cnt_q) begin
						tbl_raddr = p_p1[IW-1:0];
						j_d       = p_p1[IW-1:0];
						state_d   = S_SHDN;
					end else begin
						cnt_d   = cnt_m1;
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				end else if (left) begin
					tbl_we       = 1'b1;
					tbl_waddr    = p_m1[IW-1:0];
					tbl_wdata.lo = prev_q.lo;
					tbl_wdata.hi = id_q;
					fin          = 1'b1;
					state_d      = S_IDLE;
				end else if (right) begin
					tbl_we       = 1'b1;
					tbl_waddr    = p_q[IW-1:0];
					tbl_wdata.lo = id_q;
					tbl_wdata.hi = tbl_rdata.hi;
					fin          = 1'b1;
					state_d      = S_IDLE;
				end else if (cnt_q >= CNT_MAX) begin
					fin     = 1'b1;
					fin_st  = ST_FULL;
					state_d = S_IDLE;
				end else if (cnt_q > p_q) begin
					// open a slot at p: move the top entries up, highest first
					tbl_raddr = cnt_m1[IW-1:0];
					j_d       = cnt_m1[IW-1:0];
					state_d   = S_SHUP;
				end else begin
					tbl_we       = 1'b1;
					tbl_waddr    = p_q[IW-1:0];
					tbl_wdata.lo = id_q;
					tbl_wdata.hi = id_q;
					cnt_d        = cnt_q + CNT_ONE;
					fin          = 1'b1;
					state_d      = S_IDLE;
				end
			end

			S_SHDN: begin
				tbl_we    = 1'b1;
				tbl_waddr = j_q - 1'b1;
				tbl_wdata = tbl_rdata;
				if (j_p1 == cnt_q) begin
					cnt_d   = cnt_m1;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					tbl_raddr = j_p1[IW-1:0];
					j_d       = j_p1[IW-1:0];
				end
			end

			S_SHUP: begin
				tbl_we    = 1'b1;
				tbl_waddr = j_p1[IW-1:0];
				tbl_wdata = tbl_rdata;
				if (CW'(j_q) == p_q) begin
					state_d = S_INS;
				end else begin
					tbl_raddr = j_q - 1'b1;
					j_d       = j_q - 1'b1;
				end
			end

			S_INS: begin
				tbl_we       = 1'b1;
				tbl_waddr    = p_q[IW-1:0];
				tbl_wdata.lo = id_q;
				tbl_wdata.hi = id_q;
				cnt_d        = cnt_q + CNT_ONE;
				fin          = 1'b1;
				state_d      = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A register write reloads the allocator as at reset; the user must write only while idle (unchecked).
		if (cfg_we) begin
			cnt_d = '0;
			if (cfg_index == CFG_ORDER_MODE) begin
				ctr_d = start_q;
				fb_d  = (cfg_wdata[1:0] == MODE_RANDOM);
			end else begin
				ctr_d = cfg_wdata;
				fb_d  = (mode_q == MODE_RANDOM);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_ASC;
			start_q <= '0;
			ctr_q   <= '0;
			fb_q    <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ctr_q   <= ctr_d;
			fb_q    <= fb_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
			if (cfg_we) begin
				if (cfg_index == CFG_ORDER_MODE) begin
					mode_q <= cfg_wdata[1:0];
				end else begin
					start_q <= cfg_wdata;
				end
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		res_id_q <= res_id_d;
		p_q      <= p_d;
		j_q      <= j_d;
		prev_q   <= prev_d;
		if ((state_q == S_IDLE) && start) begin
			id_q <= id_in;
		end
		if (fin) begin
			id_out_q <= fin_id;
			status_q <= fin_st;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign id_out      = id_out_q;
	assign status      = status_q;
	// outside register writes the flag only moves during an allocate, so in the strobe cycle it is the after-value
	assign in_fallback = fb_q;

endmodule

/* sv/idafr_checker.sv */
// Port-level checks for the ID allocator, attached to the top level by bind.
// Depends on idafr_pkg for status codes.
module idafr_checker #(
	parameter int INVALID_VALUE = 65535
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [idafr_pkg::ID_W-1:0] id_out,
	input logic [1:0]                 status
);
	import idafr_pkg::*;

	localparam logic [ID_W-1:0] INVALID = ID_W'(INVALID_VALUE);

	// an accepted word always makes the sequencer busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// the strobe comes as the sequencer drops back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a request");

	// every request passes through a busy state before its strobe, so strobes never touch
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// a refused allocate reports the invalid ID
	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_NO_ID)) |-> (id_out == INVALID))
		else $error("no-ID status without the invalid ID");

endmodule

bind id_allocator_free_ranges idafr_checker #(
	.INVALID_VALUE(INVALID_VALUE)
) u_idafr_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.id_out(id_out),
	.status(status)
);

/* tb/id_allocator_free_ranges_test.sv */
// Self-checking testbench for id_allocator_free_ranges: allocate and free words with a
// built-in predictor of the counter, fallback flag and free-range table.
// Depends on idafr_pkg and the id_allocator_free_ranges RTL; reads no files.
`timescale 1ns / 1ps

module id_allocator_free_ranges_test;
	import idafr_pkg::*;

	localparam int ID_LIMIT      = 65534;
	localparam int INVALID_ID    = 65535;
	localparam int MAX_RANGES    = 16;
	localparam int RANDOM_ITEMS  = 340;
	localparam int STEADY_ITEMS  = 60;
	// A free may walk and shift the whole table; the limit covers that, the longest sender
	// hold-off and a wide margin.
	localparam int STALL_LIMIT   = 2000;

	// one expected result word
	typedef struct packed {
		logic [ID_W-1:0] id;
		status_t         st;
		logic            fb;
	} reply_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic            op;
	logic [ID_W-1:0] id_in;
	logic            done;
	logic [ID_W-1:0] id_out;
	logic [1:0]      status;
	logic            in_fallback;
	logic            cfg_we;
	logic            cfg_index;
	logic [ID_W-1:0] cfg_wdata;

	id_allocator_free_ranges #(
		.ID_LIMIT      (ID_LIMIT),
		.INVALID_VALUE (INVALID_ID),
		.MAX_RANGES    (MAX_RANGES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.id_in       (id_in),
		.done        (done),
		.id_out      (id_out),
		.status      (status),
		.in_fallback (in_fallback),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the registers, the ID counter,
	// the sticky fallback flag and the sorted table of free ranges.
	// ------------------------------------------------------------------
	order_mode_t     cur_mode;
	logic [ID_W-1:0] cur_start;
	logic [ID_W-1:0] counter;
	logic            fallback;
	logic [ID_W-1:0] free_lo [MAX_RANGES];
	logic [ID_W-1:0] free_hi [MAX_RANGES];
	int              free_cnt;

	reply_t replies_due[$];
	int     errors;
	int     sent;
	bit     calm;
	int     quiet;

	// Reload as after any register write: counter from start value, flag from mode,
	// table emptied.
	function automatic void reload_pool();
		counter  = cur_start;
		fallback = (cur_mode == MODE_RANDOM);
		free_cnt = 0;
	endfunction

	// Take the lowest free ID; drop the first range when it runs empty.
	function automatic logic [ID_W-1:0] take_lowest();
		logic [ID_W-1:0] v;
		v = free_lo[0];
		if (free_lo[0] == free_hi[0]) begin
			for (int i = 1; i < free_cnt; i++) begin
				free_lo[i-1] = free_lo[i];
				free_hi[i-1] = free_hi[i];
			end
			free_cnt--;
		end else begin
			free_lo[0] = free_lo[0] + 1'b1;
		end
		return v;
	endfunction

	// Counter exhausted in ascending/descending mode: latch fallback, serve from pool.
	function automatic reply_t serve_pool();
		reply_t w;
		fallback = 1'b1;
		w.st = ST_OK;
		w.fb = 1'b1;
		if (free_cnt == 0) begin
			w.st = ST_NO_ID;
			w.id = ID_W'(INVALID_ID);
		end else begin
			w.id = take_lowest();
		end
		return w;
	endfunction

	function automatic reply_t allocate_id();
		reply_t w;
		w.st = ST_OK;
		w.id = ID_W'(INVALID_ID);
		case (cur_mode)
			MODE_RANDOM: begin
				// freed IDs always go out first, lowest one first
				if (free_cnt != 0) begin
					w.id = take_lowest();
				end else if (counter < ID_LIMIT) begin
					w.id = counter;
					counter = counter + 1'b1;
				end else begin
					w.st = ST_NO_ID;
				end
			end
			MODE_ASC: begin
				if (!fallback && counter < ID_LIMIT) begin
					w.id = counter;
					counter = counter + 1'b1;
				end else begin
					w = serve_pool();
				end
			end
			MODE_DESC: begin
				// zero is never handed out by the counter
				if (!fallback && counter != 0 && counter <= ID_LIMIT) begin
					w.id = counter;
					counter = counter - 1'b1;
				end else begin
					w = serve_pool();
				end
			end
			default: begin
				// undefined mode: refuse, touch nothing
				w.st = ST_NO_ID;
			end
		endcase
		w.fb = fallback;
		return w;
	endfunction

	// Merge one ID into the range table.
	function automatic status_t free_id(logic [ID_W-1:0] id);
		int p;
		bit join_below;
		bit join_above;
		if (id == INVALID_ID || id > ID_LIMIT)
			return ST_IGNORED;
		p = 0;
		while (p < free_cnt && free_lo[p] <= id)
			p++;
		// already inside a free range: double free
		if (p > 0 && id <= free_hi[p-1])
			return ST_IGNORED;
		join_below = (p > 0) && (free_hi[p-1] + 1 == id);
		join_above = (p < free_cnt) && (free_lo[p] == id + 1);
		if (join_below && join_above) begin
			// the ID closes the gap between two ranges
			free_hi[p-1] = free_hi[p];
			for (int i = p + 1; i < free_cnt; i++) begin
				free_lo[i-1] = free_lo[i];
				free_hi[i-1] = free_hi[i];
			end
			free_cnt--;
		end else if (join_below) begin
			free_hi[p-1] = id;
		end else if (join_above) begin
			free_lo[p] = id;
		end else begin
			// a new range is needed; no room means the free is dropped
			if (free_cnt >= MAX_RANGES)
				return ST_FULL;
			for (int i = free_cnt; i > p; i--) begin
				free_lo[i] = free_lo[i-1];
				free_hi[i] = free_hi[i-1];
			end
			free_lo[p] = id;
			free_hi[p] = id;
			free_cnt++;
		end
		return ST_OK;
	endfunction

	// ------------------------------------------------------------------
	// Driving: everything changes at the falling edge.
	// ------------------------------------------------------------------

	// Present one word and hold it until accepted (start high, busy low at a rising edge).
	// Leave start high on return so a following word goes back to back.
	task automatic issue(input logic kind, input logic [ID_W-1:0] id);
		reply_t r;
		@(negedge clk);
		start = 1'b1;
		op    = kind;
		id_in = id;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (kind == OP_ALLOC) begin
			r = allocate_id();
		end else begin
			r.st = free_id(id);
			r.id = id;
			r.fb = fallback;
		end
		replies_due.push_back(r);
		sent++;
	endtask

	// Unless calm, drop start for a burst of random length, at the given odds in percent.
	task automatic maybe_hold(input int pct);
		if (!calm && $urandom_range(0, 99) < pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 16))
				@(negedge clk);
		end
	endtask

	// Stop sending and wait until every expected word has come back and the block is idle.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (replies_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	// Register write; only called after settle() or right after reset.
	task automatic write_reg(input logic idx, input logic [ID_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		if (idx == CFG_ORDER_MODE)
			cur_mode = order_mode_t'(val[1:0]);
		else
			cur_start = val;
		reload_pool();
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_mode_and_start(input order_mode_t m, input logic [ID_W-1:0] s);
		settle();
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_ORDER_MODE, ID_W'(m));
			write_reg(CFG_START_VALUE, s);
		end else begin
			write_reg(CFG_START_VALUE, s);
			write_reg(CFG_ORDER_MODE, ID_W'(m));
		end
	endtask

	// Free ID mostly from a 48-wide window so ranges touch, merge, repeat and fill up;
	// now and then a full-width, the top valid or the invalid value.
	function automatic logic [ID_W-1:0] pick_free_id(input logic [ID_W-1:0] base);
		int r;
		r = $urandom_range(0, 31);
		if (r == 0)
			return ID_W'(INVALID_ID);
		if (r < 3)
			return ID_W'($urandom);
		if (r == 3)
			return ID_W'(ID_LIMIT);
		return base + ID_W'($urandom_range(0, 47));
	endfunction

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Reset defaults: ascending from 0, no fallback. Top valid ID is freeable,
	// the invalid ID and a double free are ignored.
	task automatic test_ascending_basics();
		issue(OP_ALLOC, 16'hFFFF);
		issue(OP_FREE, ID_W'(INVALID_ID));
		issue(OP_FREE, ID_W'(ID_LIMIT));
		issue(OP_FREE, ID_W'(ID_LIMIT));
		issue(OP_ALLOC, 16'h0000);
	endtask

	// Run the counter off the top, then serve from the pool, joining two ranges on the way.
	task automatic test_ascending_fallback();
		set_mode_and_start(MODE_ASC, ID_W'(ID_LIMIT - 1));
		issue(OP_ALLOC, 16'h0);
		issue(OP_ALLOC, 16'h0);
		issue(OP_FREE, 16'd9);
		issue(OP_FREE, 16'd11);
		issue(OP_FREE, 16'd10);
		issue(OP_ALLOC, 16'h0);
	endtask

	// Count down to 1, then fall back; a start above the limit is exhausted at once.
	task automatic test_descending();
		set_mode_and_start(MODE_DESC, 16'd2);
		issue(OP_ALLOC, 16'h0);
		issue(OP_ALLOC, 16'h0);
		issue(OP_ALLOC, 16'h0);
		issue(OP_FREE, 16'd0);
		issue(OP_ALLOC, 16'h0);
		set_mode_and_start(MODE_DESC, 16'hFFFF);
		issue(OP_ALLOC, 16'h0);
	endtask

	// Random-reuse with a spent counter: nothing to give until an ID is freed.
	task automatic test_random_reuse();
		set_mode_and_start(MODE_RANDOM, ID_W'(ID_LIMIT));
		issue(OP_ALLOC, 16'h0);
		issue(OP_FREE, 16'd5);
		issue(OP_ALLOC, 16'h0);
	endtask

	// Undefined mode refuses allocates but still takes frees.
	task automatic test_undefined_mode();
		set_mode_and_start(MODE_UNDEF, 16'd0);
		issue(OP_ALLOC, 16'h0);
		issue(OP_FREE, 16'd3);
	endtask

	// ------------------------------------------------------------------
	// Random tests
	// ------------------------------------------------------------------

	// Fill all ranges in random order, overflow, open a slot by a merge, then churn.
	task automatic test_table_full();
		logic [ID_W-1:0] base;
		logic [ID_W-1:0] outlier;
		logic [ID_W-1:0] t;
		logic [ID_W-1:0] slot [MAX_RANGES];
		int              j;
		set_mode_and_start(MODE_ASC, 16'd0);
		if ($urandom_range(0, 1))
			base = ID_W'(ID_LIMIT - 2*MAX_RANGES + 1);
		else
			base = ID_W'($urandom_range(0, ID_LIMIT - 3*MAX_RANGES));
		for (int k = 0; k < MAX_RANGES; k++)
			slot[k] = base + ID_W'(2*k);
		for (int k = MAX_RANGES - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = slot[k];
			slot[k] = slot[j];
			slot[j] = t;
		end
		foreach (slot[k])
			issue(OP_FREE, slot[k]);
		outlier = (base >= 2) ? base - 2'd2 : base + ID_W'(2*MAX_RANGES);
		issue(OP_FREE, outlier);
		issue(OP_FREE, base + 1'b1);
		issue(OP_FREE, outlier);
		issue(OP_FREE, base + ID_W'(2*MAX_RANGES - 2));
		repeat (20) begin
			if ($urandom_range(0, 2) == 0)
				issue(OP_ALLOC, ID_W'($urandom));
			else
				issue(OP_FREE, base + ID_W'($urandom_range(0, 2*MAX_RANGES + 3)));
		end
	endtask

	// Phases with a random mode and start value, random op mix and random hold-off rate.
	task automatic test_mixed_traffic();
		order_mode_t     m;
		logic [ID_W-1:0] s;
		logic [ID_W-1:0] base;
		int              pick;
		int              free_pct;
		int              hold_pct;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			m = (pick < 3) ? MODE_RANDOM : (pick < 6) ? MODE_ASC :
				(pick < 9) ? MODE_DESC : MODE_UNDEF;
			// start values near both ends so the counter runs out inside a phase
			case ($urandom_range(0, 5))
				0:       s = 16'd0;
				1:       s = ID_W'(ID_LIMIT - $urandom_range(0, 20));
				2:       s = ID_W'($urandom_range(0, 20));
				3:       s = 16'hFFFF;
				default: s = ID_W'($urandom);
			endcase
			set_mode_and_start(m, s);
			case ($urandom_range(0, 2))
				0:       base = (s <= ID_LIMIT - 47) ? s : ID_W'(ID_LIMIT - 47);
				1:       base = ID_W'(ID_LIMIT - 47);
				default: base = ID_W'($urandom_range(0, ID_LIMIT - 47));
			endcase
			free_pct = $urandom_range(25, 75);
			hold_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
			repeat ($urandom_range(15, 60)) begin
				maybe_hold(hold_pct);
				if ($urandom_range(0, 99) < free_pct)
					issue(OP_FREE, pick_free_id(base));
				else
					issue(OP_ALLOC, ID_W'($urandom));
			end
		end
	endtask

	// Final stretch with no hold-offs at all.
	task automatic test_steady_stream();
		logic [ID_W-1:0] base;
		calm = 1'b1;
		set_mode_and_start(MODE_ASC, ID_W'(ID_LIMIT - 20));
		base = ID_W'(ID_LIMIT - 47);
		repeat (STEADY_ITEMS) begin
			if ($urandom_range(0, 1))
				issue(OP_FREE, pick_free_id(base));
			else
				issue(OP_ALLOC, ID_W'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking: one word per strobe, compared with the oldest expectation.
	// Sample at the rising edge, before the block updates its outputs.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("unexpected result word: id_out %0d status %0d", id_out, status);
				errors++;
			end else begin
				want = replies_due.pop_front();
				if (id_out !== want.id) begin
					$error("id_out: expected %0d, actual %0d", want.id, id_out);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					errors++;
				end
				if (in_fallback !== want.fb) begin
					$error("in_fallback: expected %0d, actual %0d", want.fb, in_fallback);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset once, then every test in turn, then drain and report.
	// ------------------------------------------------------------------
	initial begin
		errors    = 0;
		sent      = 0;
		calm      = 1'b0;
		quiet     = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		op        = OP_ALLOC;
		id_in     = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ORDER_MODE;
		cfg_wdata = '0;
		// predictor follows the reset values of the registers
		cur_mode  = MODE_ASC;
		cur_start = '0;
		reload_pool();
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_ascending_basics();
		test_ascending_fallback();
		test_descending();
		test_random_reuse();
		test_undefined_mode();
		test_table_full();
		test_mixed_traffic();
		test_steady_stream();

		// drain, then give the block time to show any stray word
		settle();
		repeat (2*MAX_RANGES + 8)
			@(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
